// ===== design/olad_pkg.sv =====
`default_nettype none

package olad_pkg;

    localparam int CAPACITY_DEF = 32;

    // command codes
    localparam logic [1:0] CMD_APPEND = 2'd0;
    localparam logic [1:0] CMD_DELETE = 2'd1;
    localparam logic [1:0] CMD_DUMP   = 2'd2;

    // result status codes
    localparam logic [2:0] ST_DONE      = 3'd0;
    localparam logic [2:0] ST_EMPTY     = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_ITEM      = 3'd4;

    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [31:0] value;
    } t_in_item;

    typedef struct packed {
        logic [2:0]         status;
        logic signed [31:0] data;
        logic               last;
    } t_out_item;

endpackage

`default_nettype wire

// ===== design/ordered_list_append_delete_core.sv =====
`default_nettype none

// ordered list of up to CAPACITY signed 32-bit values, head first
// input channel: an item (cmd, value) is taken on a rising edge with start high
// and busy low; busy stays high while a delete or dump is being worked on
// output channel: each result is held on o_result for one cycle with o_strobe
// high; the receiver cannot stall, so results are never held back or lost
// append: one result the cycle after the item, block stays ready
// delete: one result after a search and, when the value is found, a shift of the
// later entries down the list memory; an empty list answers the cycle after
// dump: one result per entry on consecutive cycles, head first, each read through
// the memory port and the result register, last set on the tail entry; an empty
// list gives one empty result
// unused command code: ignored, no result
// search, shift and dump read through the single read port of the entry memory
// with its registered read data, one entry per cycle
// reset: the entry count clears, the entry memory keeps whatever it held and is
// never read beyond the count, so no clearing pass is needed

module ordered_list_append_delete_core #(
    parameter int CAPACITY = olad_pkg::CAPACITY_DEF
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  start,
    input  olad_pkg::t_in_item   i_item,
    output logic                 busy,
    output logic                 o_strobe,
    output olad_pkg::t_out_item  o_result
);
    import olad_pkg::*;

    localparam int AW = $clog2(CAPACITY);      // entry address width
    localparam int CW = $clog2(CAPACITY + 1);  // count width, holds CAPACITY

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SEARCH = 4'b0010,
        S_SHIFT  = 4'b0100,
        S_DUMP   = 4'b1000
    } t_state;

    // entry memory, one write and one registered read per cycle
    logic signed [31:0] r_mem [CAPACITY];
    logic signed [31:0] r_rd_data;

    t_state             r_state, n_state;
    logic [CW-1:0]      r_count, n_count;      // valid entries
    logic [CW-1:0]      r_idx, n_idx;          // next read index
    logic               r_pend, n_pend;        // read data arrives this cycle
    logic [CW-1:0]      r_pend_idx, n_pend_idx;// index of that read
    logic signed [31:0] r_value, n_value;      // value to delete
    logic               r_strobe, n_strobe;
    t_out_item          r_result, n_result;

    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic signed [31:0] wr_data;
    logic               more;                  // entries left to read
    logic [CW-1:0]      wr_back;               // one below the pending index

    assign more    = (r_idx < r_count);
    assign rd_addr = r_idx[AW-1:0];
    assign wr_back = CW'(r_pend_idx - 1'b1);

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_idx      = r_idx;
        n_pend     = 1'b0;
        n_pend_idx = r_idx;
        n_value    = r_value;
        n_strobe   = 1'b0;
        n_result   = '0;
        rd_en      = 1'b0;
        wr_en      = 1'b0;
        wr_addr    = r_count[AW-1:0];
        wr_data    = i_item.value;

        // shared read stream used by search, shift and dump
        if (r_state != S_IDLE && more) begin
            rd_en  = 1'b1;
            n_pend = 1'b1;
            n_idx  = CW'(r_idx + 1'b1);
        end

        unique case (r_state)
            S_IDLE: begin
                n_pend = 1'b0;
                n_idx  = '0;
                if (start) begin
                    n_value = i_item.value;
                    unique case (i_item.cmd)
                        CMD_APPEND: begin
                            n_strobe      = 1'b1;
                            n_result.last = 1'b1;
                            if (r_count >= CW'(CAPACITY)) begin
                                n_result.status = ST_FULL;
                            end else begin
                                // write at the tail
                                wr_en           = 1'b1;
                                n_count         = CW'(r_count + 1'b1);
                                n_result.status = ST_DONE;
                            end
                        end
                        CMD_DELETE: begin
                            if (r_count == '0) begin
                                n_strobe        = 1'b1;
                                n_result.status = ST_EMPTY;
                                n_result.last   = 1'b1;
                            end else begin
                                n_state = S_SEARCH;
                            end
                        end
                        CMD_DUMP: begin
                            if (r_count == '0) begin
                                n_strobe        = 1'b1;
                                n_result.status = ST_EMPTY;
                                n_result.last   = 1'b1;
                            end else begin
                                n_state = S_DUMP;
                            end
                        end
                        default: begin
                            // unused code, nothing to do
                        end
                    endcase
                end
            end
            S_SEARCH: begin
                if (r_pend && r_rd_data == r_value) begin
                    // first match: move the later entries down from here
                    n_state = S_SHIFT;
                    n_idx   = CW'(r_pend_idx + 1'b1);
                    n_pend  = 1'b0;
                end else if (!r_pend && !more) begin
                    n_state         = S_IDLE;
                    n_strobe        = 1'b1;
                    n_result.status = ST_NOT_FOUND;
                    n_result.last   = 1'b1;
                end
            end
            S_SHIFT: begin
                if (r_pend) begin
                    wr_en   = 1'b1;
                    wr_addr = wr_back[AW-1:0];
                    wr_data = r_rd_data;
                end else if (!more) begin
                    n_state         = S_IDLE;
                    n_count         = CW'(r_count - 1'b1);
                    n_strobe        = 1'b1;
                    n_result.status = ST_DONE;
                    n_result.last   = 1'b1;
                end
            end
            S_DUMP: begin
                if (r_pend) begin
                    n_strobe        = 1'b1;
                    n_result.status = ST_ITEM;
                    n_result.data   = r_rd_data;
                    n_result.last   = (r_pend_idx == CW'(r_count - 1'b1));
                end else if (!more) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // entry memory
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_idx    <= '0;
            r_pend   <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_idx    <= n_idx;
            r_pend   <= n_pend;
            r_strobe <= n_strobe;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_pend_idx <= n_pend_idx;
        r_value    <= n_value;
        r_result   <= n_result;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

`default_nettype wire

// ===== dv/olad_checker.sv =====
`default_nettype none

module olad_checker #(
    parameter int CAPACITY = olad_pkg::CAPACITY_DEF
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_start,
    input  wire                  i_busy,
    input  olad_pkg::t_in_item   i_item,
    input  wire                  i_strobe,
    input  olad_pkg::t_out_item  i_result,
    output int                   o_fail_count,
    output int                   o_waiting,
    output int                   o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    import olad_pkg::*;

    logic signed [31:0] list_now [$];
    t_out_item          results_due [$];
    int                 fail_count = 0;
    int                 checked = 0;
    int                 waiting = 0;

    assign o_fail_count = fail_count;
    assign o_waiting    = waiting;
    assign o_checked    = checked;

    function automatic t_out_item make_result(input logic [2:0] status,
                                              input logic signed [31:0] data,
                                              input logic last);
        t_out_item r;
        r.status = status;
        r.data   = data;
        r.last   = last;
        return r;
    endfunction

    // apply one item to the list copy and queue the results it gives
    task automatic work_out_results(input t_in_item it);
        int hit;
        hit = -1;
        case (it.cmd)
            CMD_APPEND: begin
                if (list_now.size() >= CAPACITY) begin
                    results_due.push_back(make_result(ST_FULL, '0, 1'b1));
                end else begin
                    list_now.push_back(it.value);
                    results_due.push_back(make_result(ST_DONE, '0, 1'b1));
                end
            end
            CMD_DELETE: begin
                if (list_now.size() == 0) begin
                    results_due.push_back(make_result(ST_EMPTY, '0, 1'b1));
                end else begin
                    // first match from the head
                    foreach (list_now[i]) begin
                        if (hit < 0 && list_now[i] == it.value) hit = i;
                    end
                    if (hit < 0) begin
                        results_due.push_back(make_result(ST_NOT_FOUND, '0, 1'b1));
                    end else begin
                        list_now.delete(hit);
                        results_due.push_back(make_result(ST_DONE, '0, 1'b1));
                    end
                end
            end
            CMD_DUMP: begin
                if (list_now.size() == 0) begin
                    results_due.push_back(make_result(ST_EMPTY, '0, 1'b1));
                end else begin
                    foreach (list_now[i]) begin
                        results_due.push_back(make_result(ST_ITEM, list_now[i],
                                                          i == list_now.size() - 1));
                    end
                end
            end
            default: begin
                // unused code, no result
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            list_now.delete();
            results_due.delete();
        end else begin
            // results first: an item taken at this edge cannot answer at it
            if (i_strobe) begin
                if (results_due.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%t unexpected result: status %0d data %0d last %0b",
                                 $realtime, i_result.status, i_result.data, i_result.last);
                end else begin
                    want = results_due.pop_front();
                    checked++;
                    if (i_result.status !== want.status || i_result.data !== want.data ||
                        i_result.last !== want.last) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("%t mismatch: expected %0d %0d %0b, got %0d %0d %0b",
                                     $realtime, want.status, want.data, want.last,
                                     i_result.status, i_result.data, i_result.last);
                    end
                end
            end
            if (i_start && !i_busy) work_out_results(i_item);
        end
        waiting = results_due.size();
    end

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import olad_pkg::*;

    localparam int                 LIST_CAP   = CAPACITY_DEF;
    // the one command code the block ignores
    localparam logic [1:0]         CMD_UNUSED = 2'd3;
    localparam logic signed [31:0] MIN_VAL    = 32'sh8000_0000;
    localparam logic signed [31:0] MAX_VAL    = 32'sh7fff_ffff;

    logic      i_clk;
    logic      i_rst_n;
    logic      start;
    logic      busy;
    logic      o_strobe;
    t_in_item  i_item;
    t_out_item o_result;

    int fail_count;
    int waiting;
    int checked;

    // items issued per command code, for the summary
    int issued [4];

    // small pool of values so that deletes hit and duplicates pile up
    logic signed [31:0] value_pool [8];

    // set for stretches where the sender never pauses
    bit quiet;

    ordered_list_append_delete_core #(
        .CAPACITY(LIST_CAP)
    ) DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_item   (i_item),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    olad_checker #(
        .CAPACITY(LIST_CAP)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_item       (i_item),
        .i_strobe     (o_strobe),
        .i_result     (o_result),
        .o_fail_count (fail_count),
        .o_waiting    (waiting),
        .o_checked    (checked)
    );

    // 10 ns clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // hard stop in case the block hangs or a result never turns up
    initial begin
        #2ms;
        $display("timeout with %0d results still outstanding", waiting);
        $display("RESULT: ERROR");
        $finish;
    end

    // random pause before an item: mostly none or short, now and then long;
    // the inputs carry noise while start is low
    task automatic idle_gap();
        int n;
        int r;
        n = 0;
        if (!quiet) begin
            r = $urandom_range(99);
            if (r >= 90)      n = $urandom_range(40, 8);
            else if (r >= 55) n = $urandom_range(3, 1);
        end
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) begin
                i_item <= {2'($urandom_range(3)), 32'($urandom)};
                @(negedge i_clk);
            end
        end
    endtask

    // present one item at a falling edge and hold it until busy is low at a rising edge
    task automatic issue(input logic [1:0] cmd, input logic signed [31:0] value);
        idle_gap();
        i_item.cmd   <= cmd;
        i_item.value <= value;
        start        <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        issued[cmd]++;
        @(negedge i_clk);
    endtask

    // sender holds off until every outstanding result has come back
    task automatic drain();
        start <= 1'b0;
        @(negedge i_clk);
        while (waiting != 0) @(negedge i_clk);
    endtask

    function automatic logic signed [31:0] pick_value(input int pool_pct);
        if ($urandom_range(99) < pool_pct) return value_pool[$urandom_range(7)];
        return 32'($urandom);
    endfunction

    // a stretch of random items, biased towards filling or towards emptying the list
    task automatic run_block(input bit grow, input int n);
        int r;
        quiet = ($urandom_range(3) == 0);
        repeat (n) begin
            r = $urandom_range(99);
            if (r < (grow ? 80 : 25))      issue(CMD_APPEND, pick_value(75));
            else if (r < (grow ? 93 : 80)) issue(CMD_DELETE, pick_value(80));
            else if (r < 97)               issue(CMD_DUMP, 32'($urandom));
            else                           issue(CMD_UNUSED, 32'($urandom));
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        start   = 1'b0;
        i_item  = '0;
        quiet   = 1'b0;
        foreach (issued[k]) issued[k] = 0;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty list cases first
        issue(CMD_DUMP,   32'sd0);
        issue(CMD_DELETE, 32'sd5);
        issue(CMD_UNUSED, -32'sd1);
        // extremes of the value field, with a duplicate of the maximum
        issue(CMD_APPEND, MIN_VAL);
        issue(CMD_APPEND, MAX_VAL);
        issue(CMD_APPEND, 32'sd0);
        issue(CMD_APPEND, -32'sd1);
        issue(CMD_APPEND, MAX_VAL);
        issue(CMD_DUMP,   32'sd0);
        // no match, then first of two duplicates, head, tail
        issue(CMD_DELETE, 32'sd12345);
        issue(CMD_DELETE, MAX_VAL);
        issue(CMD_DELETE, MIN_VAL);
        issue(CMD_DELETE, MAX_VAL);
        issue(CMD_DUMP,   32'sd0);
        // empty it again and dump a single entry
        issue(CMD_DELETE, -32'sd1);
        issue(CMD_DELETE, 32'sd0);
        issue(CMD_DUMP,   -32'sd1);
        issue(CMD_UNUSED, 32'sh5555_aaaa);
        issue(CMD_APPEND, 32'sh5555_aaaa);
        issue(CMD_DUMP,   32'sh2aaa_5555);

        value_pool[0] = MIN_VAL;
        value_pool[1] = MAX_VAL;
        value_pool[2] = 32'sd0;
        value_pool[3] = -32'sd1;
        for (int k = 4; k < 8; k++) value_pool[k] = 32'($urandom);

        // fill well past capacity so that appends get dropped, then dump the full list
        repeat (LIST_CAP + 2) issue(CMD_APPEND, pick_value(75));
        issue(CMD_DUMP, 32'($urandom));
        drain();

        // random part: alternate draining and refilling
        run_block(1'b0, 32);
        run_block(1'b1, 32);
        drain();
        run_block(1'b0, 32);
        run_block(1'b1, 32);

        // wind down: wait for the last results, then allow for stray ones
        start <= 1'b0;
        @(negedge i_clk);
        while (waiting != 0) @(negedge i_clk);
        repeat (2 * LIST_CAP + 16) @(posedge i_clk);

        $display("issued %0d appends, %0d deletes, %0d dumps and %0d unused codes",
                 issued[CMD_APPEND], issued[CMD_DELETE], issued[CMD_DUMP],
                 issued[CMD_UNUSED]);
        $display("%0d results checked, %0d failures", checked, fail_count);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
